### rtl/svc_pkg.sv
// ----------------------------------------------------------------------------
// svc_pkg: shared types and constants of the sparse voxel chunk store
// Holds the sizes of the chunk table and voxel memory, and the transfer types.
// ----------------------------------------------------------------------------
package svc_pkg;

  localparam int CHUNK_DIM_LOG2 = 3;
  localparam int CHUNK_SLOTS    = 64;
  localparam int COORD_BITS     = 16;
  localparam int VALUE_BITS     = 16;

  localparam int KEY_W   = COORD_BITS - CHUNK_DIM_LOG2;
  localparam int SLOT_W  = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
  localparam int CNT_W   = $clog2(CHUNK_SLOTS + 1);
  localparam int OFFS_W  = 3 * CHUNK_DIM_LOG2;
  localparam int VOX_NUM = CHUNK_SLOTS * (2 ** OFFS_W);
  localparam int ADDR_W  = $clog2(VOX_NUM);
  localparam int Q_DEPTH = 2;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Input item.
  typedef struct packed {
    logic               cmd;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic signed [15:0] write_value;
  } in_t;

  // Result item.
  typedef struct packed {
    logic signed [15:0] read_value;
    logic               occupied;
    logic               chunk_present;
    logic               table_full;
  } out_t;

  // Classified operation passed from the front to the back.
  typedef struct packed {
    logic                  wr;
    logic                  rd;
    logic [ADDR_W-1:0]     addr;
    logic [VALUE_BITS-1:0] value;
    logic                  found;
    logic                  full;
  } op_t;

endpackage

### rtl/svc_front.sv
// ----------------------------------------------------------------------------
// svc_front: coordinate split, chunk match and slot allocation
// Matches the chunk key against all slots in parallel and allocates on a write miss while a slot is free.
// ----------------------------------------------------------------------------
module svc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  svc_pkg::in_t  item,
  output svc_pkg::op_t  op
);

  localparam int D = svc_pkg::CHUNK_DIM_LOG2;
  localparam int C = svc_pkg::COORD_BITS;

  logic [svc_pkg::KEY_W-1:0]  key_x_r [svc_pkg::CHUNK_SLOTS];
  logic [svc_pkg::KEY_W-1:0]  key_y_r [svc_pkg::CHUNK_SLOTS];
  logic [svc_pkg::KEY_W-1:0]  key_z_r [svc_pkg::CHUNK_SLOTS];
  logic [svc_pkg::CHUNK_SLOTS-1:0] valid_r, valid_nxt;
  logic [svc_pkg::CNT_W-1:0]  used_r, used_nxt;

  logic [C-1:0] ux, uy, uz;
  logic [svc_pkg::KEY_W-1:0] kx, ky, kz;
  logic [svc_pkg::CHUNK_SLOTS-1:0] hit;
  logic [svc_pkg::SLOT_W-1:0] hit_slot, slot;
  logic found, full, alloc, store;
  logic signed [svc_pkg::VALUE_BITS-1:0] fit;

  // Wrap coordinates to the coordinate width and split them.
  assign ux = C'(item.coord_x);
  assign uy = C'(item.coord_y);
  assign uz = C'(item.coord_z);
  assign kx = ux[C-1:D];
  assign ky = uy[C-1:D];
  assign kz = uz[C-1:D];
  assign fit = svc_pkg::VALUE_BITS'(item.write_value);

  // Parallel key compare over all slots.
  always_comb begin
    for (int i = 0; i < svc_pkg::CHUNK_SLOTS; i++) begin
      hit[i] = valid_r[i] && key_x_r[i] == kx && key_y_r[i] == ky && key_z_r[i] == kz;
    end
  end

  // Lowest matching slot.
  always_comb begin
    hit_slot = '0;
    for (int i = svc_pkg::CHUNK_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) hit_slot = svc_pkg::SLOT_W'(i);
    end
  end

  assign found = |hit;
  assign full  = (used_r == svc_pkg::CNT_W'(svc_pkg::CHUNK_SLOTS));
  assign alloc = (item.cmd == svc_pkg::CMD_WRITE) && !found && !full;
  assign store = (item.cmd == svc_pkg::CMD_WRITE) && (found || !full);
  assign slot  = found ? hit_slot : used_r[svc_pkg::SLOT_W-1:0];

  // Classified operation.
  always_comb begin
    op.wr    = store;
    op.rd    = (item.cmd == svc_pkg::CMD_READ) && found;
    op.addr  = {slot, ux[D-1:0], uy[D-1:0], uz[D-1:0]};
    op.value = store ? fit : '0;
    op.found = found;
    op.full  = (item.cmd == svc_pkg::CMD_WRITE) && !found && full;
  end

  // Allocation bookkeeping.
  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    if (accept && alloc) begin
      valid_nxt[slot] = 1'b1;
      used_nxt        = used_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
    end
  end

  // Key table entries need no reset; they are qualified by the valid bits.
  always_ff @(posedge clk) begin
    if (accept && alloc) begin
      key_x_r[slot] <= kx;
      key_y_r[slot] <= ky;
      key_z_r[slot] <= kz;
    end
  end

endmodule

### rtl/svc_queue.sv
// ----------------------------------------------------------------------------
// svc_queue: short operation queue between front and back
// A two-entry first-in first-out buffer of classified operations.
// ----------------------------------------------------------------------------
module svc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  svc_pkg::op_t  push_op,
  input  logic          pop,
  output svc_pkg::op_t  head_op,
  output logic          not_empty,
  output logic          full
);

  localparam int PW = $clog2(svc_pkg::Q_DEPTH);

  svc_pkg::op_t   mem_r [svc_pkg::Q_DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (PW+1)'(svc_pkg::Q_DEPTH));
  assign head_op   = mem_r[rp_r];

  // Pointer and count update.
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_op;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
    else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
      (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not advance on push");
`endif

endmodule

### rtl/svc_back.sv
// ----------------------------------------------------------------------------
// svc_back: voxel memory access and result register
// Clears the voxel memory after reset, then performs one operation at a time.
// ----------------------------------------------------------------------------
module svc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_valid,
  input  svc_pkg::op_t  op,
  output logic          pop,
  output logic          busy,
  output logic          out_valid,
  input  logic          out_stall,
  output svc_pkg::out_t out_data
);

  logic [svc_pkg::VALUE_BITS-1:0] mem [svc_pkg::VOX_NUM];
  logic [svc_pkg::ADDR_W:0]       clr_r, clr_nxt;
  logic [svc_pkg::VALUE_BITS-1:0] rdata_r;
  svc_pkg::op_t                   s1_r;
  logic                           s1_valid_r, s1_valid_nxt;
  logic                           out_valid_r, out_valid_nxt;
  svc_pkg::out_t                  out_r;
  logic [svc_pkg::VALUE_BITS-1:0] res;

  assign busy = !clr_r[svc_pkg::ADDR_W];
  assign pop  = op_valid && !busy && !s1_valid_r && (!out_valid_r || !out_stall);
  assign res  = s1_r.rd ? rdata_r : s1_r.value;

  // Control state: clearing sweep, access stage and output register.
  always_comb begin
    clr_nxt       = busy ? clr_r + 1'b1 : clr_r;
    s1_valid_nxt  = pop;
    out_valid_nxt = s1_valid_r || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Voxel memory: one write port shared by the clearing sweep, one read port.
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_r[svc_pkg::ADDR_W-1:0]] <= '0;
    end else if (pop && op.wr) begin
      mem[op.addr] <= op.value;
    end
    if (pop && op.rd) rdata_r <= mem[op.addr];
  end

  // Payload of the access stage and result register.
  always_ff @(posedge clk) begin
    if (pop) s1_r <= op;
    if (s1_valid_r) begin
      out_r.read_value    <= 16'(res);
      out_r.occupied      <= (res != '0);
      out_r.chunk_present <= s1_r.found;
      out_r.table_full    <= s1_r.full;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/sparse_voxel_chunk_store.sv
// ----------------------------------------------------------------------------
// sparse_voxel_chunk_store: sparse chunked voxel grid
// Reads and writes signed 16-bit voxel values in allocated chunks.
// ----------------------------------------------------------------------------
// After reset the block clears its 32768 voxel memory entries, one entry
// per cycle, and holds in_stall high meanwhile. Afterwards an item is
// classified by a parallel chunk match in the cycle it is transferred and
// queued; the back end takes an item only when its access stage is empty,
// so it cannot take a new item before the last has left that stage, and
// uses the single voxel memory port and its registered read data; the
// result passes through the access stage and the result register.
module sparse_voxel_chunk_store (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  svc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output svc_pkg::out_t out_data
);

  svc_pkg::op_t fr_op, hd_op;
  logic accept, pop, q_ne, q_full, busy;

  // Input transfer when the queue has room and the memory is cleared.
  assign in_stall = busy || q_full;
  assign accept   = in_valid && !in_stall;

  svc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .op     (fr_op)
  );

  svc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_op   (fr_op),
    .pop       (pop),
    .head_op   (hd_op),
    .not_empty (q_ne),
    .full      (q_full)
  );

  svc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_ne),
    .op        (hd_op),
    .pop       (pop),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### tb/svc_checker.sv
// ----------------------------------------------------------------------------
// Sparse voxel chunk store result checker
// Watches both channels, keeps its own copy of the chunk table and the voxel
// memory, predicts every result and compares it with the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module svc_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  svc_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  svc_pkg::out_t out_data,
  output int            fail_count,
  output int            pending_count,
  output int            result_count
);

  // Shadow chunk table and voxel memory.
  logic [svc_pkg::KEY_W-1:0]      key_x [svc_pkg::CHUNK_SLOTS];
  logic [svc_pkg::KEY_W-1:0]      key_y [svc_pkg::CHUNK_SLOTS];
  logic [svc_pkg::KEY_W-1:0]      key_z [svc_pkg::CHUNK_SLOTS];
  logic                           slot_live [svc_pkg::CHUNK_SLOTS];
  int                             next_slot;
  logic [svc_pkg::VALUE_BITS-1:0] voxels [svc_pkg::VOX_NUM];
  svc_pkg::out_t                  expected_results [$];

  // Chunk coordinate: arithmetic shift, i.e. floor division by the chunk edge.
  function automatic logic [svc_pkg::KEY_W-1:0] in_data_key(logic signed [15:0] c);
    return c[svc_pkg::COORD_BITS-1:svc_pkg::CHUNK_DIM_LOG2];
  endfunction

  // Work out the result of one accepted access and update the shadow state.
  function automatic svc_pkg::out_t access_voxel(svc_pkg::in_t item);
    svc_pkg::out_t                  res;
    logic [svc_pkg::KEY_W-1:0]      kx, ky, kz;
    logic [svc_pkg::OFFS_W-1:0]     offs;
    int                             slot;
    logic                           hit;
    logic [svc_pkg::VALUE_BITS-1:0] val;
    kx = in_data_key(item.coord_x);
    ky = in_data_key(item.coord_y);
    kz = in_data_key(item.coord_z);
    offs = {item.coord_x[svc_pkg::CHUNK_DIM_LOG2-1:0],
            item.coord_y[svc_pkg::CHUNK_DIM_LOG2-1:0],
            item.coord_z[svc_pkg::CHUNK_DIM_LOG2-1:0]};
    hit = 1'b0;
    slot = 0;
    val = '0;
    res = '0;
    for (int i = 0; i < svc_pkg::CHUNK_SLOTS; i++) begin
      if (!hit && slot_live[i] && key_x[i] == kx && key_y[i] == ky && key_z[i] == kz) begin
        hit = 1'b1;
        slot = i;
      end
    end
    if (item.cmd == svc_pkg::CMD_READ) begin
      if (hit) val = voxels[slot * (2 ** svc_pkg::OFFS_W) + offs];
    end else if (!hit && next_slot >= svc_pkg::CHUNK_SLOTS) begin
      res.table_full = 1'b1;
    end else begin
      if (!hit) begin
        slot = next_slot;
        slot_live[slot] = 1'b1;
        key_x[slot] = kx;
        key_y[slot] = ky;
        key_z[slot] = kz;
        next_slot++;
      end
      val = item.write_value[svc_pkg::VALUE_BITS-1:0];
      voxels[slot * (2 ** svc_pkg::OFFS_W) + offs] = val;
    end
    res.read_value = val;
    res.occupied = (val != '0);
    res.chunk_present = hit;
    return res;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    svc_pkg::out_t want;
    if (!rst_n) begin
      for (int i = 0; i < svc_pkg::CHUNK_SLOTS; i++) slot_live[i] = 1'b0;
      for (int i = 0; i < svc_pkg::VOX_NUM; i++) voxels[i] = '0;
      next_slot = 0;
      fail_count <= 0;
      result_count <= 0;
      expected_results.delete();
    end else begin
      // Accepted input transfer: predict its result.
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(), access_voxel(in_data));
      end
      // Accepted result transfer: compare with the oldest prediction.
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.read_value !== out_data.read_value ||
              want.occupied !== out_data.occupied ||
              want.chunk_present !== out_data.chunk_present ||
              want.table_full !== out_data.table_full) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Sparse voxel chunk store testbench
// Drives directed and random voxel reads and writes with random gaps and
// output stalls, fills the chunk table, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 900000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  svc_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  svc_pkg::out_t out_data;
  int   fail_count, pending_count, result_count;
  int   cycles = 0;
  int   sent = 0;
  logic long_hold = 1'b0;
  logic signed [15:0] near_x [8];
  logic signed [15:0] near_y [8];
  logic signed [15:0] near_z [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sparse_voxel_chunk_store u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  svc_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  // Offer one access and hold it until the transfer, then idle for the given gap.
  task automatic send_access(logic cmd, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic signed [15:0] v, int gap);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{cmd: cmd, coord_x: x, coord_y: y, coord_z: z, write_value: v};
    do @(posedge clk); while (in_stall);
    sent++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Random gap: often none, so back-to-back stretches occur.
  function automatic int draw_gap(int mode);
    if (mode == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stall per cycle stretch, plus one long hold-off.
  initial begin
    int wait_cycles;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
      end else begin
        wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles - 1) @(negedge clk);
          @(negedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 17)) begin
          @(negedge clk);
          if (long_hold) out_stall <= 1'b1;
        end
      end
    end
  end

  initial begin
    int mode;
    int idx;
    logic signed [15:0] x, y, z;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, negative floor division, fresh chunk reads.
    send_access(svc_pkg::CMD_READ,  16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 0);
    send_access(svc_pkg::CMD_WRITE, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff, 1);
    send_access(svc_pkg::CMD_READ,  16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 0);
    send_access(svc_pkg::CMD_READ,  16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000, 2);
    send_access(svc_pkg::CMD_WRITE, -16'sd1, -16'sd1, -16'sd1, -16'sd32768, 0);
    send_access(svc_pkg::CMD_READ,  -16'sd1, -16'sd1, -16'sd1, 16'sh0000, 0);
    send_access(svc_pkg::CMD_READ,  -16'sd8, -16'sd8, -16'sd8, 16'sh0000, 0);
    send_access(svc_pkg::CMD_READ,  -16'sd9, -16'sd1, -16'sd1, 16'sh0000, 0);
    send_access(svc_pkg::CMD_WRITE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh5555, 3);
    send_access(svc_pkg::CMD_WRITE, -16'sd32768, -16'sd32768, -16'sd32768, 16'shaaaa, 0);
    send_access(svc_pkg::CMD_READ,  16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh0000, 0);
    send_access(svc_pkg::CMD_READ,  -16'sd32768, -16'sd32768, -16'sd32768, 16'sh0000, 0);
    send_access(svc_pkg::CMD_WRITE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh0000, 0);
    send_access(svc_pkg::CMD_READ,  16'sh7fff, 16'sh7fff, 16'sh7fff, 16'shffff, 0);
    send_access(svc_pkg::CMD_WRITE, 16'sh7ff8, 16'sh0007, -16'sd32761, 16'sh0001, 0);

    // Random: mostly accesses near a small set of chunks, some scattered.
    for (int i = 0; i < 8; i++) begin
      near_x[i] = $urandom; near_y[i] = $urandom; near_z[i] = $urandom;
    end
    for (int n = 0; n < 1750; n++) begin
      mode = $urandom_range(0, 2);
      // Long receiver hold-off while the sender keeps offering items.
      if (n == 300) begin
        long_hold <= 1'b1;
        fork
          begin repeat (300) @(negedge clk); long_hold <= 1'b0; end
        join_none
      end
      // Sender pause until every prediction has been matched.
      if (n == 900) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
      end
      if ($urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, 7);
        x = near_x[idx] + $signed(16'($urandom_range(0, 15)) - 16'sd8);
        y = near_y[idx] + $signed(16'($urandom_range(0, 15)) - 16'sd8);
        z = near_z[idx] + $signed(16'($urandom_range(0, 15)) - 16'sd8);
      end else begin
        x = $urandom; y = $urandom; z = $urandom;
      end
      send_access(logic'($urandom_range(0, 1)), x, y, z,
                  ($urandom_range(0, 7) == 0) ? 16'sh0000 : 16'($urandom),
                  draw_gap(mode));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d voxel accesses, checked %0d results with random gaps and stalls.",
             sent, result_count);
    $display("Chunk table was filled past capacity so dropped writes were exercised.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
